[hdl/irpd_pkg.sv]
// Shared types and constants of the pulse-distance IR frame encoder.
package irpd_pkg;

  localparam int unsigned DataW     = 8;
  localparam int unsigned BitIdxW   = $clog2(DataW);
  localparam int unsigned ShortDurW = 16;
  localparam int unsigned DurW      = 20;
  localparam int unsigned CfgIdxW   = 3;
  localparam int unsigned CfgDataW  = DurW;
  localparam int unsigned QDepth    = 2;
  localparam int unsigned QPtrW     = $clog2(QDepth);
  localparam int unsigned QCntW     = $clog2(QDepth + 1);
  localparam int unsigned OutDataW  = 24;

  localparam logic [ShortDurW-1:0] HdrMarkRst  = 16'd3300;
  localparam logic [ShortDurW-1:0] HdrSpaceRst = 16'd1700;
  localparam logic [ShortDurW-1:0] BitMarkRst  = 16'd400;
  localparam logic [ShortDurW-1:0] OneSpaceRst = 16'd1250;
  localparam logic [ShortDurW-1:0] ZeroSpcRst  = 16'd500;
  localparam logic [DurW-1:0]      FrameGapRst = 20'd100000;

  typedef enum logic [CfgIdxW-1:0] {
    REG_HDR_MARK  = 3'd0,
    REG_HDR_SPACE = 3'd1,
    REG_BIT_MARK  = 3'd2,
    REG_ONE_SPACE = 3'd3,
    REG_ZERO_SPC  = 3'd4,
    REG_FRAME_GAP = 3'd5,
    REG_BIT_ORDER = 3'd6
  } irpd_reg_e;

  // bit_order: 1 sends the least significant bit of each byte first.
  typedef struct packed {
    logic [ShortDurW-1:0] hdr_mark;
    logic [ShortDurW-1:0] hdr_space;
    logic [ShortDurW-1:0] bit_mark;
    logic [ShortDurW-1:0] one_space;
    logic [ShortDurW-1:0] zero_space;
    logic [DurW-1:0]      frame_gap;
    logic                 bit_order;
  } irpd_cfg_t;

  // One classified byte: bits already in send order (index 0 goes first).
  typedef struct packed {
    logic [DataW-1:0] bits;
    logic             header;
    logic             last;
  } irpd_item_t;

  typedef enum logic [6:0] {
    ST_IDLE      = 7'b0000001,
    ST_HDR_MARK  = 7'b0000010,
    ST_HDR_SPACE = 7'b0000100,
    ST_BIT_MARK  = 7'b0001000,
    ST_BIT_SPACE = 7'b0010000,
    ST_TRL_MARK  = 7'b0100000,
    ST_GAP       = 7'b1000000
  } irpd_state_e;

endpackage

[hdl/irpd_front.sv]
// Input side: accepts bytes, tracks the open frame and classifies each byte.
module irpd_front (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       s_axis_tvalid,
  output logic                       s_axis_tready,
  input  logic [irpd_pkg::DataW-1:0] s_axis_tdata,
  input  logic                       s_axis_tlast,
  input  logic                       bit_order_i,
  input  logic                       q_full_i,
  output logic                       q_push_o,
  output irpd_pkg::irpd_item_t       q_item_o
);
  import irpd_pkg::*;

  logic frame_open_d, frame_open_q;
  logic [DataW-1:0] ordered;

  assign s_axis_tready = ~q_full_i;
  assign q_push_o      = s_axis_tvalid & ~q_full_i;

  // For MSB-first sending the byte is mirrored so the back end always walks up.
  always_comb begin
    for (int i = 0; i < DataW; i++) begin
      ordered[i] = bit_order_i ? s_axis_tdata[i] : s_axis_tdata[DataW-1-i];
    end
  end

  assign q_item_o.bits   = ordered;
  assign q_item_o.header = ~frame_open_q;
  assign q_item_o.last   = s_axis_tlast;

  assign frame_open_d = q_push_o ? ~s_axis_tlast : frame_open_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_open_q <= 1'b0;
    end else begin
      frame_open_q <= frame_open_d;
    end
  end

endmodule

[hdl/irpd_fifo.sv]
// Two-entry queue of classified bytes between the front and the sequencer.
module irpd_fifo (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  input  irpd_pkg::irpd_item_t push_item_i,
  output logic                 full_o,
  input  logic                 pop_i,
  output logic                 valid_o,
  output irpd_pkg::irpd_item_t pop_item_o
);
  import irpd_pkg::*;

  irpd_item_t             mem_q [QDepth];
  logic [QPtrW-1:0]       wr_ptr_d, wr_ptr_q, rd_ptr_d, rd_ptr_q;
  logic [QCntW-1:0]       cnt_d, cnt_q;

  assign full_o     = (cnt_q == QCntW'(QDepth));
  assign valid_o    = (cnt_q != '0);
  assign pop_item_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == QPtrW'(QDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == QPtrW'(QDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_item_i;
    end
  end

endmodule

[hdl/irpd_seq.sv]
// Output side: steps through the segments of each queued byte.
module irpd_seq (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  irpd_pkg::irpd_cfg_t           cfg_i,
  input  logic                          q_valid_i,
  input  irpd_pkg::irpd_item_t          q_item_i,
  output logic                          q_pop_o,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [irpd_pkg::OutDataW-1:0] m_axis_tdata,
  output logic                          m_axis_tlast,
  output logic [1:0]                    m_axis_tuser
);
  import irpd_pkg::*;

  irpd_state_e          state_d, state_q;
  irpd_item_t           cur_d, cur_q;
  logic [BitIdxW-1:0]   bit_d, bit_q;
  logic                 adv, emit, done, start;
  logic                 seg_level, seg_run_end, seg_frame_end;
  logic [DurW-1:0]      seg_dur;

  logic                 out_valid_d, out_valid_q;
  logic                 level_q, run_end_q, frame_end_q;
  logic [DurW-1:0]      dur_q;

  // The output register is free when empty or being drained this cycle.
  assign adv = ~out_valid_q | m_axis_tready;

  always_comb begin
    state_d       = state_q;
    cur_d         = cur_q;
    bit_d         = bit_q;
    emit          = 1'b0;
    done          = 1'b0;
    seg_level     = 1'b0;
    seg_dur       = '0;
    seg_run_end   = 1'b0;
    seg_frame_end = 1'b0;
    case (state_q)
      ST_IDLE: begin
        done = 1'b1;
      end
      ST_HDR_MARK: begin
        if (adv) begin
          emit      = 1'b1;
          seg_level = 1'b1;
          seg_dur   = DurW'(cfg_i.hdr_mark);
          state_d   = ST_HDR_SPACE;
        end
      end
      ST_HDR_SPACE: begin
        if (adv) begin
          emit    = 1'b1;
          seg_dur = DurW'(cfg_i.hdr_space);
          state_d = ST_BIT_MARK;
        end
      end
      ST_BIT_MARK: begin
        if (adv) begin
          emit      = 1'b1;
          seg_level = 1'b1;
          seg_dur   = DurW'(cfg_i.bit_mark);
          state_d   = ST_BIT_SPACE;
        end
      end
      ST_BIT_SPACE: begin
        if (adv) begin
          emit    = 1'b1;
          seg_dur = cur_q.bits[bit_q] ? DurW'(cfg_i.one_space) : DurW'(cfg_i.zero_space);
          if (bit_q == BitIdxW'(DataW - 1)) begin
            if (cur_q.last) begin
              state_d = ST_TRL_MARK;
            end else begin
              seg_run_end = 1'b1;
              done        = 1'b1;
            end
          end else begin
            bit_d   = bit_q + 1'b1;
            state_d = ST_BIT_MARK;
          end
        end
      end
      ST_TRL_MARK: begin
        if (adv) begin
          emit      = 1'b1;
          seg_level = 1'b1;
          seg_dur   = DurW'(cfg_i.bit_mark);
          state_d   = ST_GAP;
        end
      end
      ST_GAP: begin
        if (adv) begin
          emit          = 1'b1;
          seg_dur       = cfg_i.frame_gap;
          seg_run_end   = 1'b1;
          seg_frame_end = 1'b1;
          done          = 1'b1;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    // A finished byte hands over to the next queued one in the same cycle.
    start = done & q_valid_i;
    if (start) begin
      cur_d   = q_item_i;
      bit_d   = '0;
      state_d = q_item_i.header ? ST_HDR_MARK : ST_BIT_MARK;
    end else if (done) begin
      state_d = ST_IDLE;
    end
  end

  assign q_pop_o     = start;
  assign out_valid_d = adv ? emit : out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      bit_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      bit_q       <= bit_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q <= cur_d;
    if (emit) begin
      level_q     <= seg_level;
      dur_q       <= seg_dur;
      run_end_q   <= seg_run_end;
      frame_end_q <= seg_frame_end;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = OutDataW'(dur_q);
  assign m_axis_tlast  = run_end_q;
  assign m_axis_tuser  = {frame_end_q, level_q};

endmodule

[hdl/ir_pulse_distance_frame_encoder.sv]
// Top level of the pulse-distance IR frame encoder: registers, front, queue, sequencer.
//
//   Channel   Direction  Payload
//   s_axis    in         tdata[7:0] data_byte, tlast last_byte
//   m_axis    out        tdata[19:0] duration_us, tlast run_end,
//                        tuser[0] level, tuser[1] frame_end
//   cfg       in         cfg_index_i register index, cfg_data_i value
//
// Each byte yields 16 to 20 segments, and the sequencer puts out one segment per cycle
// while the output is not stalled, through its single output register.
// A byte is taken while the two-entry queue has room, so the next bytes wait there
// while the sequencer is still busy with an earlier one.
// The sequencer moves straight from the last segment of one byte to the first of the
// next queued byte without a bubble.
// Reset (rst_ni low, asynchronous) closes any open frame, empties the queue and
// restores the register reset values; no clearing pass is needed.
// A stall on the output holds the current segment and backs up into the queue and, once it is full, to s_axis_tready.
module ir_pulse_distance_frame_encoder (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // Input stream, tdata from bit 0: data_byte[7:0].
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [irpd_pkg::DataW-1:0]    s_axis_tdata,
  input  logic                          s_axis_tlast,
  // Output stream, tdata from bit 0: duration_us[19:0], then zero fill.
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [irpd_pkg::OutDataW-1:0] m_axis_tdata,
  output logic                          m_axis_tlast,
  // tuser from bit 0: level, frame_end.
  output logic [1:0]                    m_axis_tuser,
  // Register write channel.
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [irpd_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [irpd_pkg::CfgDataW-1:0] cfg_data_i
);
  import irpd_pkg::*;

  irpd_cfg_t  cfg_q;
  irpd_item_t push_item, pop_item;
  logic       push, pop, q_full, q_valid;

  // Register writes are always taken; an unknown index is dropped.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.hdr_mark   <= HdrMarkRst;
      cfg_q.hdr_space  <= HdrSpaceRst;
      cfg_q.bit_mark   <= BitMarkRst;
      cfg_q.one_space  <= OneSpaceRst;
      cfg_q.zero_space <= ZeroSpcRst;
      cfg_q.frame_gap  <= FrameGapRst;
      cfg_q.bit_order  <= 1'b1;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_HDR_MARK:  cfg_q.hdr_mark   <= cfg_data_i[ShortDurW-1:0];
        REG_HDR_SPACE: cfg_q.hdr_space  <= cfg_data_i[ShortDurW-1:0];
        REG_BIT_MARK:  cfg_q.bit_mark   <= cfg_data_i[ShortDurW-1:0];
        REG_ONE_SPACE: cfg_q.one_space  <= cfg_data_i[ShortDurW-1:0];
        REG_ZERO_SPC:  cfg_q.zero_space <= cfg_data_i[ShortDurW-1:0];
        REG_FRAME_GAP: cfg_q.frame_gap  <= cfg_data_i[DurW-1:0];
        REG_BIT_ORDER: cfg_q.bit_order  <= cfg_data_i[0];
        default: begin
        end
      endcase
    end
  end

  // The front decides header and bit order at the moment of the transfer.
  irpd_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .bit_order_i   (cfg_q.bit_order),
    .q_full_i      (q_full),
    .q_push_o      (push),
    .q_item_o      (push_item)
  );

  irpd_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_item_i (push_item),
    .full_o      (q_full),
    .pop_i       (pop),
    .valid_o     (q_valid),
    .pop_item_o  (pop_item)
  );

  // Durations are read live; the user must change them only while idle, unenforced.
  irpd_seq u_seq (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg_q),
    .q_valid_i     (q_valid),
    .q_item_i      (pop_item),
    .q_pop_o       (pop),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
  );

endmodule

[hdl/irpd_checker.sv]
// Port-level checks of the pulse-distance IR frame encoder, bound to the top level.
module irpd_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          m_axis_tvalid,
  input logic                          m_axis_tready,
  input logic [irpd_pkg::OutDataW-1:0] m_axis_tdata,
  input logic                          m_axis_tlast,
  input logic [1:0]                    m_axis_tuser
);
  import irpd_pkg::*;

  // The frame gap always closes the run of its byte.
  a_gap_ends_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser[1] |-> m_axis_tlast)
    else $error("frame_end segment without run_end");

  // The frame gap is a space.
  a_gap_is_space: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser[1] |-> !m_axis_tuser[0])
    else $error("frame_end segment is a mark");

  // Every byte ends on a space, either a bit space or the gap.
  a_run_ends_space: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tlast |-> !m_axis_tuser[0])
    else $error("run ends on a mark");

  // A stalled segment stays put.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
      && $stable(m_axis_tuser) && $stable(m_axis_tlast))
    else $error("output changed while stalled");

endmodule

bind ir_pulse_distance_frame_encoder irpd_checker u_irpd_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast),
  .m_axis_tuser  (m_axis_tuser)
);
